// File: rtl/latency_aware_backend_selector_assert.svh
// Assertion macros shared by the checker of the backend selector
`ifndef LATENCY_AWARE_BACKEND_SELECTOR_ASSERT_SVH
`define LATENCY_AWARE_BACKEND_SELECTOR_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define LBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbs check failed");
// next-cycle implication
`define LBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbs check failed");
`endif

// File: rtl/lbs_pkg.sv
// Constants, types and helpers of the backend selector
package lbs_pkg;
  localparam int SLOTS      = 4;
  localparam int WIN_DEPTH  = 8;
  localparam int SLOT_W     = 2;
  localparam int POS_W      = 3;
  localparam int OCC_W      = 4;
  localparam int N_W        = 3;
  localparam int LAT_W      = 24;
  localparam int SUM_W      = 27;
  localparam int CNT_W      = 40;
  localparam int MEM_AW     = SLOT_W + POS_W;
  localparam int DCNT_W     = 5;
  localparam int PHASES     = 5;
  localparam int PRIM_PH    = 4;

  localparam logic [1:0] OP_PICK  = 2'd0;
  localparam logic [1:0] OP_DONE  = 2'd1;
  localparam logic [1:0] OP_KILL  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] MODE_FAST   = 3'd0;
  localparam logic [2:0] MODE_GPU_BF = 3'd1;
  localparam logic [2:0] MODE_NPU_BF = 3'd2;
  localparam logic [2:0] MODE_GPU    = 3'd3;
  localparam logic [2:0] MODE_NPU    = 3'd4;

  localparam logic [1:0] KIND_GPU = 2'd1;
  localparam logic [1:0] KIND_NPU = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_KINDS = 2'd2;

  typedef struct packed {
    logic load;
    logic chk;
    logic rd_fix;
    logic div_init;
    logic div_step;
    logic scan_step;
    logic fin;
  } lbs_cmd_t;

  typedef struct packed {
    logic fast_pick;
    logic need_push;
    logic win_full;
    logic div_last;
    logic scan_last;
    logic out_free;
  } lbs_stat_t;

  function automatic logic [SLOT_W-1:0] first_of_kind(input logic [7:0] kinds,
                                                      input logic [N_W-1:0] n,
                                                      input logic [1:0] kind);
    logic [SLOT_W-1:0] res;
    res = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (N_W'(i) < n && kinds[2*i +: 2] == kind) begin
        res = SLOT_W'(i);
      end
    end
    return res;
  endfunction
endpackage

// File: rtl/lbs_if.sv
// Item channels of the backend selector
interface lbs_in_if import lbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [SLOT_W-1:0] slot_index;
  logic [LAT_W-1:0]  latency_us;
  logic              success;
  modport source (output valid, opcode, slot_index, latency_us, success, input ready);
  modport sink (input valid, opcode, slot_index, latency_us, success, output ready);
endinterface

interface lbs_out_if import lbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              chosen_valid;
  logic [SLOT_W-1:0] chosen_slot;
  logic [LAT_W-1:0]  window_average_us;
  logic [OCC_W-1:0]  window_fill;
  logic [CNT_W-1:0]  completed_count;
  logic [CNT_W-1:0]  failed_count;
  logic              slot_alive;
  logic              bad_slot;
  modport source (output valid, chosen_valid, chosen_slot, window_average_us, window_fill,
                  completed_count, failed_count, slot_alive, bad_slot, input ready);
  modport sink (input valid, chosen_valid, chosen_slot, window_average_us, window_fill,
                completed_count, failed_count, slot_alive, bad_slot, output ready);
endinterface

// File: rtl/lbs_ctrl.sv
// Sequencing state machine of the backend selector
module lbs_ctrl import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lbs_stat_t stat,
  output lbs_cmd_t  cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DIVI = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        priority if (stat.fast_pick) state_nxt = S_SCAN;
        else if (stat.need_push) state_nxt = stat.win_full ? S_RD : S_DIVI;
        else state_nxt = S_FIN;
      end
      S_RD: begin
        cmd.rd_fix = 1'b1;
        state_nxt  = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// File: rtl/lbs_dp.sv
// Slot statistics, window memory, divider, scan and result register
module lbs_dp import lbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lbs_cmd_t          cmd,
  output lbs_stat_t         stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [1:0]        in_opcode,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic [LAT_W-1:0]  in_latency_us,
  input  logic              in_success,
  lbs_out_if.source         out_ch
);
  logic [2:0] mode_r;
  logic [N_W-1:0] count_r;
  logic [7:0] kinds_r;

  logic [1:0]        op_r;
  logic [SLOT_W-1:0] idx_r;
  logic [LAT_W-1:0]  lat_r;
  logic              ok_r;

  logic [SUM_W-1:0] sum_r   [SLOTS];
  logic [OCC_W-1:0] occ_r   [SLOTS];
  logic [POS_W-1:0] old_r   [SLOTS];
  logic             alive_r [SLOTS];
  logic [CNT_W-1:0] done_r  [SLOTS];
  logic [CNT_W-1:0] fail_r  [SLOTS];
  logic [LAT_W-1:0] avg_r   [SLOTS];
  logic [2:0]       phase_r;
  logic [SLOT_W-1:0] chosen_r;

  logic [LAT_W-1:0] mem [2**MEM_AW];
  logic [LAT_W-1:0] rd_data_r;

  logic [2:0]        rem_r;
  logic [SUM_W-1:0]  q_r;
  logic [OCC_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic [SLOT_W-1:0] scan_r;
  logic              found_r, fa_found_r;
  logic [SLOT_W-1:0] best_r, fa_r;
  logic [LAT_W-1:0]  min_avg_r;

  logic                out_valid_r, out_cv_r, out_alive_r, out_bad_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [LAT_W-1:0]    out_avg_r;
  logic [OCC_W-1:0]    out_fill_r;
  logic [CNT_W-1:0]    out_done_r, out_fail_r;

  logic [N_W-1:0] n;
  logic bad, is_pick, fast_mode;
  logic [3:0] rem_w;
  logic ge;
  logic [SUM_W-1:0] q_nxt;
  logic [SLOT_W-1:0] fast_sel, rep;

  assign n         = (count_r > N_W'(SLOTS)) ? N_W'(SLOTS) : count_r;
  assign is_pick   = (op_r == OP_PICK);
  assign bad       = !is_pick && ({1'b0, idx_r} >= n);
  assign fast_mode = (mode_r == MODE_FAST) || (mode_r > MODE_NPU);

  assign rem_w = {rem_r, q_r[SUM_W-1]};
  assign ge    = (rem_w >= dvs_r);
  assign q_nxt = {q_r[SUM_W-2:0], ge};

  assign fast_sel = found_r ? best_r : (fa_found_r ? fa_r : '0);
  assign rep      = is_pick ? ((fast_mode && n > N_W'(1)) ? fast_sel : chosen_r) : idx_r;

  always_comb begin
    stat.fast_pick = is_pick && fast_mode && (n > N_W'(1));
    stat.need_push = (op_r == OP_DONE) && !bad && ok_r;
    stat.win_full  = (occ_r[idx_r] == OCC_W'(WIN_DEPTH));
    stat.div_last  = (dcnt_r == DCNT_W'(SUM_W - 1));
    stat.scan_last = (scan_r == SLOT_W'(SLOTS - 1));
    stat.out_free  = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      count_r <= '0;
      kinds_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[2:0];
        REG_COUNT: count_r <= cfg_data[N_W-1:0];
        REG_KINDS: kinds_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      idx_r <= in_slot_index;
      lat_r <= in_latency_us;
      ok_r  <= in_success;
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.chk && stat.need_push && !stat.win_full) begin
      mem[{idx_r, POS_W'(old_r[idx_r] + occ_r[idx_r][POS_W-1:0])}] <= lat_r;
    end else if (cmd.rd_fix) begin
      mem[{idx_r, old_r[idx_r]}] <= lat_r;
    end
    rd_data_r <= mem[{idx_r, old_r[idx_r]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        sum_r[i]   <= '0;
        occ_r[i]   <= '0;
        old_r[i]   <= '0;
        alive_r[i] <= 1'b1;
        done_r[i]  <= '0;
        fail_r[i]  <= '0;
        avg_r[i]   <= '0;
      end
      phase_r <= '0;
    end else begin
      if (cmd.chk) begin
        if (is_pick) begin
          if (n > N_W'(1) && (mode_r == MODE_GPU_BF || mode_r == MODE_NPU_BF)) begin
            phase_r <= (phase_r == 3'(PHASES - 1)) ? '0 : phase_r + 3'd1;
          end
        end else if (!bad) begin
          unique case (op_r)
            OP_DONE: begin
              if (done_r[idx_r] != '1) done_r[idx_r] <= done_r[idx_r] + CNT_W'(1);
              if (!ok_r) begin
                if (fail_r[idx_r] != '1) fail_r[idx_r] <= fail_r[idx_r] + CNT_W'(1);
              end else if (!stat.win_full) begin
                occ_r[idx_r] <= occ_r[idx_r] + OCC_W'(1);
                sum_r[idx_r] <= sum_r[idx_r] + SUM_W'(lat_r);
              end
            end
            OP_KILL: alive_r[idx_r] <= 1'b0;
            OP_CLEAR: begin
              done_r[idx_r]  <= '0;
              fail_r[idx_r]  <= '0;
              alive_r[idx_r] <= 1'b1;
            end
            default: ;
          endcase
        end
      end
      if (cmd.rd_fix) begin
        sum_r[idx_r] <= sum_r[idx_r] - SUM_W'(rd_data_r) + SUM_W'(lat_r);
        old_r[idx_r] <= old_r[idx_r] + POS_W'(1);
      end
      if (cmd.div_step && stat.div_last) avg_r[idx_r] <= q_nxt[LAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      chosen_r   <= '0;
      scan_r     <= '0;
      found_r    <= 1'b0;
      fa_found_r <= 1'b0;
      if (n > N_W'(1)) begin
        unique case (mode_r)
          MODE_GPU_BF: chosen_r <= first_of_kind(kinds_r, n,
                          (phase_r < 3'(PRIM_PH)) ? KIND_GPU : KIND_NPU);
          MODE_NPU_BF: chosen_r <= first_of_kind(kinds_r, n,
                          (phase_r < 3'(PRIM_PH)) ? KIND_NPU : KIND_GPU);
          MODE_GPU:    chosen_r <= first_of_kind(kinds_r, n, KIND_GPU);
          MODE_NPU:    chosen_r <= first_of_kind(kinds_r, n, KIND_NPU);
          default:     chosen_r <= '0;
        endcase
      end
    end
    if (cmd.scan_step) begin
      scan_r <= scan_r + SLOT_W'(1);
      if ({1'b0, scan_r} < n) begin
        if (alive_r[scan_r] && occ_r[scan_r] != '0 &&
            (!found_r || avg_r[scan_r] < min_avg_r)) begin
          found_r   <= 1'b1;
          best_r    <= scan_r;
          min_avg_r <= avg_r[scan_r];
        end
        if (alive_r[scan_r] && !fa_found_r) begin
          fa_found_r <= 1'b1;
          fa_r       <= scan_r;
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= '0;
      q_r    <= sum_r[idx_r];
      dvs_r  <= occ_r[idx_r];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? 3'(rem_w - dvs_r) : rem_w[2:0];
      q_r    <= q_nxt;
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_cv_r    <= 1'b0;
      out_slot_r  <= '0;
      out_avg_r   <= '0;
      out_fill_r  <= '0;
      out_done_r  <= '0;
      out_fail_r  <= '0;
      out_alive_r <= 1'b0;
      out_bad_r   <= bad;
      if (!bad && !(is_pick && n == '0)) begin
        out_cv_r    <= is_pick;
        out_slot_r  <= is_pick ? rep : '0;
        out_avg_r   <= avg_r[rep];
        out_fill_r  <= occ_r[rep];
        out_done_r  <= done_r[rep];
        out_fail_r  <= fail_r[rep];
        out_alive_r <= alive_r[rep];
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.chosen_valid      = out_cv_r;
  assign out_ch.chosen_slot       = out_slot_r;
  assign out_ch.window_average_us = out_avg_r;
  assign out_ch.window_fill       = out_fill_r;
  assign out_ch.completed_count   = out_done_r;
  assign out_ch.failed_count      = out_fail_r;
  assign out_ch.slot_alive        = out_alive_r;
  assign out_ch.bad_slot          = out_bad_r;
endmodule

// File: rtl/latency_aware_backend_selector.sv
// Top level of the latency-aware backend selector
//
// in_ch carries one item: a pick request, a completion report, a kill or a
// clear of one slot. out_ch returns exactly one result item for each.
// cfg_we/cfg_index/cfg_data write strategy mode, slot count and slot kinds;
// write them only while the block is idle.
// A fastest-mode pick scans the slots one by one before its result, and a
// successful completion report runs the 27-step restoring divider that
// refreshes the slot's cached window average. One item is in work at a
// time; the next is accepted once the previous result is registered.
// Reset clears all statistics, marks every slot alive and empties the
// result register; window memory contents are not cleared. When out_ch is
// stalled the result is held and one further item can be accepted, which
// then waits in its last step until the result register frees.
module latency_aware_backend_selector import lbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lbs_in_if.sink     in_ch,
  lbs_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  lbs_cmd_t  cmd;
  lbs_stat_t stat;

  lbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_opcode     (in_ch.opcode),
    .in_slot_index (in_ch.slot_index),
    .in_latency_us (in_ch.latency_us),
    .in_success    (in_ch.success),
    .out_ch        (out_ch)
  );
endmodule

// File: rtl/lbs_chk.sv
// Port-level checker of the backend selector and its bind
`include "latency_aware_backend_selector_assert.svh"
module lbs_chk import lbs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             chosen_valid,
  input logic             bad_slot,
  input logic [OCC_W-1:0] window_fill,
  input logic [CNT_W-1:0] completed_count,
  input logic [CNT_W-1:0] failed_count
);
  `LBS_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid)
  `LBS_ASSERT_NOW(a_bad, out_valid && bad_slot, !chosen_valid && window_fill == '0)
  `LBS_ASSERT_NOW(a_fill, out_valid, window_fill <= OCC_W'(WIN_DEPTH))
  `LBS_ASSERT_NOW(a_fail, out_valid, failed_count <= completed_count)
endmodule

bind latency_aware_backend_selector lbs_chk u_lbs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .chosen_valid    (out_ch.chosen_valid),
  .bad_slot        (out_ch.bad_slot),
  .window_fill     (out_ch.window_fill),
  .completed_count (out_ch.completed_count),
  .failed_count    (out_ch.failed_count)
);

// File: sim/lbs_selector_checker.sv
// Checker for the backend selector: mirrors slot state and compares every result item
module lbs_selector_checker import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lbs_in_if.sink      in_mon,
  lbs_out_if.sink     out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending_count
);
  typedef struct packed {
    logic             chosen_valid;
    logic [SLOT_W-1:0] chosen_slot;
    logic [LAT_W-1:0] window_average_us;
    logic [OCC_W-1:0] window_fill;
    logic [CNT_W-1:0] completed_count;
    logic [CNT_W-1:0] failed_count;
    logic             slot_alive;
    logic             bad_slot;
  } slot_report_t;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  logic [2:0] mode_q;
  logic [2:0] count_q;
  logic [7:0] kinds_q;
  logic [LAT_W-1:0] win_mem [SLOTS][WIN_DEPTH];
  logic [SUM_W-1:0] win_sum [SLOTS];
  logic [OCC_W-1:0] win_occ [SLOTS];
  logic [POS_W-1:0] win_old [SLOTS];
  logic alive [SLOTS];
  logic [CNT_W-1:0] done_cnt [SLOTS];
  logic [CNT_W-1:0] fail_cnt [SLOTS];
  int phase;
  slot_report_t expected_reports[$];
  int mismatches;

  assign fail_count = mismatches;
  assign pending_count = expected_reports.size();

  function automatic logic [SUM_W-1:0] avg_of(int s);
    if (win_occ[s] == 0) return '0;
    return win_sum[s] / win_occ[s];
  endfunction

  function automatic int first_kind(int n, logic [1:0] kind);
    for (int i = 0; i < n; i++)
      if (kinds_q[2*i +: 2] == kind) return i;
    return 0;
  endfunction

  function automatic int fastest_slot(int n);
    int best;
    logic found;
    logic [SUM_W-1:0] low_avg;
    best = 0;
    found = 0;
    low_avg = '0;
    for (int i = 0; i < n; i++) begin
      if (alive[i] && win_occ[i] != 0 && (!found || avg_of(i) < low_avg)) begin
        found = 1;
        low_avg = avg_of(i);
        best = i;
      end
    end
    if (found) return best;
    for (int i = 0; i < n; i++)
      if (alive[i]) return i;
    return 0;
  endfunction

  function automatic void fill_report(int s, inout slot_report_t r);
    r.window_average_us = LAT_W'(avg_of(s));
    r.window_fill = win_occ[s];
    r.completed_count = done_cnt[s];
    r.failed_count = fail_cnt[s];
    r.slot_alive = alive[s];
  endfunction

  task automatic predict_item(logic [1:0] op, int idx, logic [LAT_W-1:0] lat, logic ok);
    slot_report_t r;
    int n;
    int s;
    int pos;
    logic [1:0] prim;
    logic [1:0] sec;
    r = '0;
    n = (count_q > SLOTS) ? SLOTS : count_q;
    if (op == OP_PICK) begin
      if (n != 0) begin
        if (n == 1) begin
          s = 0;
        end else if (mode_q == MODE_GPU_BF || mode_q == MODE_NPU_BF) begin
          prim = (mode_q == MODE_GPU_BF) ? KIND_GPU : KIND_NPU;
          sec = (mode_q == MODE_GPU_BF) ? KIND_NPU : KIND_GPU;
          s = first_kind(n, (phase < PRIM_PH) ? prim : sec);
          phase = (phase + 1) % PHASES;
        end else if (mode_q == MODE_GPU) begin
          s = first_kind(n, KIND_GPU);
        end else if (mode_q == MODE_NPU) begin
          s = first_kind(n, KIND_NPU);
        end else begin
          s = fastest_slot(n);
        end
        r.chosen_valid = 1;
        r.chosen_slot = SLOT_W'(s);
        fill_report(s, r);
      end
    end else if (idx >= n) begin
      r.bad_slot = 1;
    end else begin
      if (op == OP_DONE) begin
        if (done_cnt[idx] != CNT_SAT) done_cnt[idx]++;
        if (!ok) begin
          if (fail_cnt[idx] != CNT_SAT) fail_cnt[idx]++;
        end else if (win_occ[idx] < WIN_DEPTH) begin
          pos = (win_old[idx] + win_occ[idx]) % WIN_DEPTH;
          win_mem[idx][pos] = lat;
          win_occ[idx]++;
          win_sum[idx] += lat;
        end else begin
          pos = win_old[idx];
          win_sum[idx] = win_sum[idx] - win_mem[idx][pos] + lat;
          win_mem[idx][pos] = lat;
          win_old[idx] = POS_W'((pos + 1) % WIN_DEPTH);
        end
      end else if (op == OP_KILL) begin
        alive[idx] = 0;
      end else begin
        done_cnt[idx] = '0;
        fail_cnt[idx] = '0;
        alive[idx] = 1;
      end
      fill_report(idx, r);
    end
    expected_reports.insert(expected_reports.size(), r);
  endtask

  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t exp_r;
    if (!rst_n) begin
      mode_q <= MODE_FAST;
      count_q <= '0;
      kinds_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        win_sum[i] = '0;
        win_occ[i] = '0;
        win_old[i] = '0;
        alive[i] = 1;
        done_cnt[i] = '0;
        fail_cnt[i] = '0;
      end
      phase = 0;
      expected_reports.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: mode_q <= cfg_data[2:0];
          REG_COUNT: count_q <= cfg_data[2:0];
          REG_KINDS: kinds_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.opcode, in_mon.slot_index, in_mon.latency_us, in_mon.success);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.chosen_valid, out_mon.chosen_slot, out_mon.window_average_us,
                out_mon.window_fill, out_mon.completed_count, out_mon.failed_count,
                out_mon.slot_alive, out_mon.bad_slot};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          exp_r = expected_reports.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
    end
  end
endmodule

// File: sim/latency_aware_backend_selector_tb.sv
// Testbench top: drives items and registers into the backend selector and reports the verdict
module latency_aware_backend_selector_tb import lbs_pkg::*;;
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_MODE;
  logic [7:0] cfg_data = '0;
  int fail_count;
  int pending_count;
  logic calm;

  lbs_in_if in_ch();
  lbs_out_if out_ch();

  latency_aware_backend_selector dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .out_ch(out_ch), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  lbs_selector_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count));

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = OP_PICK;
    in_ch.slot_index = '0;
    in_ch.latency_us = '0;
    in_ch.success = 0;
    out_ch.ready = 0;
  end

  always @(negedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 32);

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // valid stays up after an accept until the next item or an idle cycle replaces it
  task automatic send_item(logic [1:0] op, logic [1:0] idx, logic [23:0] lat, logic ok);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.slot_index <= idx;
    in_ch.latency_us <= lat;
    in_ch.success <= ok;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_phase(logic [2:0] mode, logic [2:0] cnt, logic [7:0] kinds);
    drain();
    write_reg(REG_MODE, {5'd0, mode});
    write_reg(REG_COUNT, {5'd0, cnt});
    write_reg(REG_KINDS, kinds);
  endtask

  function automatic logic [23:0] rand_lat();
    case ($urandom_range(3))
      0: return 24'($urandom_range(1000));
      1: return 24'hFFFFFF - 24'($urandom_range(20));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    calm = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed
    send_item(OP_PICK, 0, 0, 0);
    set_phase(MODE_FAST, 3'd1, 8'h00);
    send_item(OP_PICK, 0, 0, 0);
    send_item(OP_DONE, 1, 5, 1);
    set_phase(MODE_FAST, 3'd7, 8'b10_01_10_01);
    send_item(OP_PICK, 0, 0, 0);
    send_item(OP_DONE, 0, 24'hFFFFFF, 1);
    send_item(OP_DONE, 0, 24'hFFFFFF, 1);
    send_item(OP_DONE, 1, 0, 1);
    send_item(OP_DONE, 2, 0, 1);
    send_item(OP_DONE, 3, 7, 0);
    send_item(OP_PICK, 0, 0, 0);
    send_item(OP_KILL, 1, 0, 0);
    send_item(OP_PICK, 0, 0, 0);
    send_item(OP_KILL, 0, 0, 0);
    send_item(OP_KILL, 2, 0, 0);
    send_item(OP_KILL, 3, 0, 0);
    send_item(OP_PICK, 0, 0, 0);
    send_item(OP_CLEAR, 2, 0, 0);
    send_item(OP_PICK, 0, 0, 0);
    set_phase(MODE_GPU_BF, 3'd4, 8'b11_10_00_01);
    repeat (6) send_item(OP_PICK, 0, 0, 0);
    set_phase(MODE_NPU, 3'd2, 8'h00);
    send_item(OP_PICK, 0, 0, 0);
    send_item(OP_CLEAR, 3, 0, 0);
    // random phases; a calm stretch in the middle
    for (int p = 0; p < 12; p++) begin
      set_phase(3'($urandom_range(7)), (p % 4 == 0) ? 3'($urandom_range(1)) :
                3'($urandom_range(2, 7)), 8'($urandom));
      calm = (p == 5);
      for (int k = 0; k < 50; k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: send_item(OP_PICK, 2'($urandom), rand_lat(), 1'($urandom));
          4, 5, 6, 7: send_item(OP_DONE, 2'($urandom), rand_lat(), $urandom_range(4) != 0);
          8: send_item(OP_KILL, 2'($urandom), rand_lat(), 1'($urandom));
          default: send_item(OP_CLEAR, 2'($urandom), rand_lat(), 1'($urandom));
        endcase
      end
      calm = 0;
    end
    drain();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
